/* src/ara_pkg.sv */
`default_nettype none

package ara_pkg;

  // Sizing
  localparam int unsigned CLIENTS = 64;
  localparam int unsigned HOLES   = 16;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned CID_W   = $clog2(CLIENTS);
  localparam int unsigned HIDX_W  = $clog2(HOLES);
  localparam int unsigned HCNT_W  = $clog2(HOLES + 1);
  localparam int unsigned HSZ_W   = ADDR_W + 1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_HELD     = 3'd1,
    ST_RELEASED = 3'd2,
    ST_NOT_HELD = 3'd3,
    ST_FULL     = 3'd4,
    ST_OVERFLOW = 3'd5,
    ST_ZERO     = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOKUP, S_HELD, S_ASCAN, S_BUMP, S_DOWN, S_COMMIT,
    S_RSCAN, S_RJOIN, S_UP, S_INS, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    IDX_HOLD, IDX_ZERO, IDX_INC, IDX_DEC, IDX_LAST
  } idx_sel_e;

  typedef enum logic [2:0] {
    HW_NONE, HW_SPLIT, HW_DOWN, HW_UP, HW_BOTH, HW_PREV, HW_NEXT, HW_INSERT
  } hole_wr_e;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR
  } cnt_op_e;

  typedef enum logic [2:0] {
    RES_HOLD, RES_ZERO, RES_HELD, RES_HOLE, RES_BUMP
  } res_op_e;

  // Controller to datapath
  typedef struct packed {
    logic     in_ld;
    idx_sel_e idx_sel;
    hole_wr_e hole_wr;
    cnt_op_e  cnt_op;
    res_op_e  res_op;
    status_e  res_st;
    logic     held_we;
    logic     held_set;
    logic     held_clr;
    logic     held_clr_all;
    logic     bump_adv;
    logic     bump_clr;
    logic     prev_ld;
    logic     join_ld;
    logic     end_ld;
    logic     out_ld;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    opcode_e op;
    logic    req_zero;
    logic    held_valid;
    logic    idx_lt_cnt;
    logic    fits;
    logic    exact;
    logic    before_s;
    logic    join_prev;
    logic    join_next;
    logic    cnt_full;
    logic    idx_eq_pos;
    logic    cnt_eq_pos;
    logic    bump_ovf;
    logic    out_free;
  } sts_t;

endpackage

`default_nettype wire

/* src/ara_dpath.sv */
`default_nettype none

module ara_dpath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ara_pkg::cmd_t               cmd_i,
  output ara_pkg::sts_t                    sts_o,
  input  wire logic [1:0]                  opcode_i,
  input  wire logic [ara_pkg::CID_W-1:0]   client_id_i,
  input  wire logic [ara_pkg::ADDR_W-1:0]  request_size_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic [2:0]                       status_o,
  output logic [ara_pkg::ADDR_W-1:0]       range_start_o,
  output logic [ara_pkg::ADDR_W-1:0]       range_size_o
);

  localparam int unsigned AW  = ara_pkg::ADDR_W;
  localparam int unsigned SW  = ara_pkg::HSZ_W;
  localparam int unsigned CW  = ara_pkg::HCNT_W;
  localparam int unsigned IW  = ara_pkg::HIDX_W;
  localparam logic [AW+1:0] LIMIT = (AW+2)'(1) << AW;

  // Latched item
  ara_pkg::opcode_e        op_q;
  logic [ara_pkg::CID_W-1:0] cid_q;
  logic [AW-1:0]           req_q;

  // Client table
  logic [ara_pkg::CLIENTS-1:0] held_valid_q;
  logic [2*AW-1:0] held_mem [ara_pkg::CLIENTS];
  logic [2*AW-1:0] held_rd_q;

  // Free list, entry = {size, start}
  logic [SW+AW-1:0] hole_mem [ara_pkg::HOLES];
  logic [SW+AW-1:0] hole_rd_q;
  logic [AW-1:0]    rd_start;
  logic [SW-1:0]    rd_size;

  logic [CW-1:0] idx_q, idx_d, cnt_q, pos_q;
  logic [AW:0]   bump_q;
  logic [AW-1:0] prev_start_q;
  logic [SW-1:0] prev_size_q;
  logic [AW+1:0] prev_end_q;
  logic [AW:0]   end_q;
  logic          jp_q, jn_q, jp_now, jn_now;

  logic [2:0]    res_st_q;
  logic [AW-1:0] res_start_q, res_size_q;
  logic [SW-1:0] z_ext;
  logic [AW+1:0] bump_sum;

  logic            hole_we;
  logic [CW-1:0]   hole_waddr;
  logic [SW+AW-1:0] hole_wdata;

  assign rd_start = hole_rd_q[AW-1:0];
  assign rd_size  = hole_rd_q[SW+AW-1:AW];
  assign z_ext    = {1'b0, res_size_q};
  assign bump_sum = {1'b0, bump_q} + {2'b0, req_q};

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_ld) begin
      op_q  <= ara_pkg::opcode_e'(opcode_i);
      cid_q <= client_id_i;
      req_q <= request_size_i;
    end
  end

  // Scan index, next value also addresses the free-list read
  always_comb begin
    case (cmd_i.idx_sel)
      ara_pkg::IDX_ZERO: idx_d = '0;
      ara_pkg::IDX_INC:  idx_d = idx_q + CW'(1);
      ara_pkg::IDX_DEC:  idx_d = idx_q - CW'(1);
      ara_pkg::IDX_LAST: idx_d = cnt_q - CW'(1);
      default:           idx_d = idx_q;
    endcase
  end

  // Free-list write port
  always_comb begin
    hole_we    = 1'b1;
    hole_waddr = idx_q;
    hole_wdata = hole_rd_q;
    case (cmd_i.hole_wr)
      ara_pkg::HW_SPLIT:  hole_wdata = {rd_size - {1'b0, req_q}, rd_start + req_q};
      ara_pkg::HW_DOWN:   hole_waddr = idx_q - CW'(1);
      ara_pkg::HW_UP:     hole_waddr = idx_q + CW'(1);
      ara_pkg::HW_BOTH: begin
        hole_waddr = idx_q - CW'(1);
        hole_wdata = {prev_size_q + z_ext + rd_size, prev_start_q};
      end
      ara_pkg::HW_PREV: begin
        hole_waddr = idx_q - CW'(1);
        hole_wdata = {prev_size_q + z_ext, prev_start_q};
      end
      ara_pkg::HW_NEXT:   hole_wdata = {rd_size + z_ext, res_start_q};
      ara_pkg::HW_INSERT: begin
        hole_waddr = pos_q;
        hole_wdata = {z_ext, res_start_q};
      end
      default:            hole_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hole_we) hole_mem[hole_waddr[IW-1:0]] <= hole_wdata;
    hole_rd_q <= hole_mem[idx_d[IW-1:0]];
  end

  // Client table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.held_we) held_mem[cid_q] <= {res_size_q, res_start_q};
    held_rd_q <= held_mem[cid_q];
  end

  // Join tests at the insertion point
  assign jp_now = (idx_q != '0) && (prev_end_q == {2'b0, res_start_q});
  assign jn_now = (idx_q < cnt_q) && (end_q == {1'b0, rd_start});

  // Release scratch
  always_ff @(posedge clk_i) begin
    if (cmd_i.prev_ld) begin
      prev_start_q <= rd_start;
      prev_size_q  <= rd_size;
      prev_end_q   <= {2'b0, rd_start} + {1'b0, rd_size};
    end
    if (cmd_i.end_ld) begin
      end_q <= {1'b0, held_rd_q[AW-1:0]} + {1'b0, held_rd_q[2*AW-1:AW]};
    end
    if (cmd_i.join_ld) begin
      pos_q <= idx_q;
      jp_q  <= jp_now;
      jn_q  <= jn_now;
    end
  end

  // Result scratch
  always_ff @(posedge clk_i) begin
    case (cmd_i.res_op)
      ara_pkg::RES_ZERO: begin
        res_st_q    <= cmd_i.res_st;
        res_start_q <= '0;
        res_size_q  <= '0;
      end
      ara_pkg::RES_HELD: begin
        res_st_q    <= cmd_i.res_st;
        res_start_q <= held_rd_q[AW-1:0];
        res_size_q  <= held_rd_q[2*AW-1:AW];
      end
      ara_pkg::RES_HOLE: begin
        res_st_q    <= cmd_i.res_st;
        res_start_q <= rd_start;
        res_size_q  <= req_q;
      end
      ara_pkg::RES_BUMP: begin
        res_st_q    <= cmd_i.res_st;
        res_start_q <= bump_q[AW-1:0];
        res_size_q  <= req_q;
      end
      default: ;
    endcase
  end

  // Control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      bump_q       <= '0;
      out_valid_o  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.held_clr_all)  held_valid_q        <= '0;
      else if (cmd_i.held_set) held_valid_q[cid_q] <= 1'b1;
      else if (cmd_i.held_clr) held_valid_q[cid_q] <= 1'b0;
      case (cmd_i.cnt_op)
        ara_pkg::CNT_INC: cnt_q <= cnt_q + CW'(1);
        ara_pkg::CNT_DEC: cnt_q <= cnt_q - CW'(1);
        ara_pkg::CNT_CLR: cnt_q <= '0;
        default: ;
      endcase
      if (cmd_i.bump_clr)      bump_q <= '0;
      else if (cmd_i.bump_adv) bump_q <= bump_sum[AW:0];
      if (cmd_i.out_ld)        out_valid_o <= 1'b1;
      else if (out_ready_i)    out_valid_o <= 1'b0;
    end
  end

  // Output item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      status_o      <= res_st_q;
      range_start_o <= res_start_q;
      range_size_o  <= res_size_q;
    end
  end

  // Status
  always_comb begin
    sts_o.op         = op_q;
    sts_o.req_zero   = (req_q == '0);
    sts_o.held_valid = held_valid_q[cid_q];
    sts_o.idx_lt_cnt = (idx_q < cnt_q);
    sts_o.fits       = (rd_size >= {1'b0, req_q});
    sts_o.exact      = (rd_size == {1'b0, req_q});
    sts_o.before_s   = (rd_start < res_start_q);
    sts_o.join_prev  = jp_q;
    sts_o.join_next  = jn_q;
    sts_o.cnt_full   = (cnt_q >= CW'(ara_pkg::HOLES));
    sts_o.idx_eq_pos = (idx_q == pos_q);
    sts_o.cnt_eq_pos = (cnt_q == pos_q);
    sts_o.bump_ovf   = (bump_sum > LIMIT);
    sts_o.out_free   = !out_valid_o || out_ready_i;
  end

endmodule

`default_nettype wire

/* src/ara_ctrl.sv */
`default_nettype none

module ara_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ara_pkg::sts_t sts_i,
  output ara_pkg::cmd_t      cmd_o
);

  ara_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ara_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  assign in_ready_o = (state_q == ara_pkg::S_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ara_pkg::S_IDLE:   if (in_valid_i) state_d = ara_pkg::S_LOOKUP;
      ara_pkg::S_LOOKUP: begin
        case (sts_i.op)
          ara_pkg::OP_ALLOC:
            state_d = sts_i.req_zero ? ara_pkg::S_DONE : ara_pkg::S_HELD;
          ara_pkg::OP_RELEASE:
            state_d = sts_i.held_valid ? ara_pkg::S_HELD : ara_pkg::S_DONE;
          default: state_d = ara_pkg::S_DONE;
        endcase
      end
      ara_pkg::S_HELD: begin
        if (sts_i.op == ara_pkg::OP_RELEASE) state_d = ara_pkg::S_RSCAN;
        else if (sts_i.held_valid)           state_d = ara_pkg::S_DONE;
        else                                 state_d = ara_pkg::S_ASCAN;
      end
      ara_pkg::S_ASCAN: begin
        if (!sts_i.idx_lt_cnt) state_d = ara_pkg::S_BUMP;
        else if (sts_i.fits)   state_d = sts_i.exact ? ara_pkg::S_DOWN : ara_pkg::S_COMMIT;
      end
      ara_pkg::S_BUMP:   state_d = sts_i.bump_ovf ? ara_pkg::S_DONE : ara_pkg::S_COMMIT;
      ara_pkg::S_DOWN: begin
        if (!sts_i.idx_lt_cnt) begin
          state_d = (sts_i.op == ara_pkg::OP_ALLOC) ? ara_pkg::S_COMMIT : ara_pkg::S_DONE;
        end
      end
      ara_pkg::S_COMMIT: state_d = ara_pkg::S_DONE;
      ara_pkg::S_RSCAN:  if (!(sts_i.idx_lt_cnt && sts_i.before_s)) state_d = ara_pkg::S_RJOIN;
      ara_pkg::S_RJOIN: begin
        if (sts_i.join_prev && sts_i.join_next)    state_d = ara_pkg::S_DOWN;
        else if (sts_i.join_prev || sts_i.join_next) state_d = ara_pkg::S_DONE;
        else if (sts_i.cnt_full)                   state_d = ara_pkg::S_DONE;
        else if (sts_i.cnt_eq_pos)                 state_d = ara_pkg::S_INS;
        else                                       state_d = ara_pkg::S_UP;
      end
      ara_pkg::S_UP:     if (sts_i.idx_eq_pos) state_d = ara_pkg::S_INS;
      ara_pkg::S_INS:    state_d = ara_pkg::S_DONE;
      ara_pkg::S_DONE:   if (sts_i.out_free) state_d = ara_pkg::S_IDLE;
      default:           state_d = ara_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ara_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_ld   = 1'b1;
          cmd_o.idx_sel = ara_pkg::IDX_ZERO;
        end
      end
      ara_pkg::S_LOOKUP: begin
        case (sts_i.op)
          ara_pkg::OP_ALLOC: begin
            if (sts_i.req_zero) begin
              cmd_o.res_op = ara_pkg::RES_ZERO;
              cmd_o.res_st = ara_pkg::ST_ZERO;
            end
          end
          ara_pkg::OP_RELEASE: begin
            if (!sts_i.held_valid) begin
              cmd_o.res_op = ara_pkg::RES_ZERO;
              cmd_o.res_st = ara_pkg::ST_NOT_HELD;
            end
          end
          ara_pkg::OP_CLEAR: begin
            cmd_o.held_clr_all = 1'b1;
            cmd_o.cnt_op       = ara_pkg::CNT_CLR;
            cmd_o.bump_clr     = 1'b1;
            cmd_o.res_op       = ara_pkg::RES_ZERO;
            cmd_o.res_st       = ara_pkg::ST_RELEASED;
          end
          default: begin
            cmd_o.res_op = ara_pkg::RES_ZERO;
            cmd_o.res_st = ara_pkg::ST_NOT_HELD;
          end
        endcase
      end
      ara_pkg::S_HELD: begin
        if (sts_i.op == ara_pkg::OP_RELEASE) begin
          cmd_o.res_op = ara_pkg::RES_HELD;
          cmd_o.res_st = ara_pkg::ST_RELEASED;
          cmd_o.end_ld = 1'b1;
        end else if (sts_i.held_valid) begin
          cmd_o.res_op = ara_pkg::RES_HELD;
          cmd_o.res_st = ara_pkg::ST_HELD;
        end
      end
      ara_pkg::S_ASCAN: begin
        if (sts_i.idx_lt_cnt) begin
          if (sts_i.fits) begin
            cmd_o.res_op = ara_pkg::RES_HOLE;
            cmd_o.res_st = ara_pkg::ST_NEW;
            if (sts_i.exact) cmd_o.idx_sel = ara_pkg::IDX_INC;
            else             cmd_o.hole_wr = ara_pkg::HW_SPLIT;
          end else begin
            cmd_o.idx_sel = ara_pkg::IDX_INC;
          end
        end
      end
      ara_pkg::S_BUMP: begin
        if (sts_i.bump_ovf) begin
          cmd_o.res_op = ara_pkg::RES_ZERO;
          cmd_o.res_st = ara_pkg::ST_OVERFLOW;
        end else begin
          cmd_o.res_op   = ara_pkg::RES_BUMP;
          cmd_o.res_st   = ara_pkg::ST_NEW;
          cmd_o.bump_adv = 1'b1;
        end
      end
      ara_pkg::S_DOWN: begin
        if (sts_i.idx_lt_cnt) begin
          cmd_o.hole_wr = ara_pkg::HW_DOWN;
          cmd_o.idx_sel = ara_pkg::IDX_INC;
        end else begin
          cmd_o.cnt_op = ara_pkg::CNT_DEC;
        end
      end
      ara_pkg::S_COMMIT: begin
        cmd_o.held_we  = 1'b1;
        cmd_o.held_set = 1'b1;
      end
      ara_pkg::S_RSCAN: begin
        if (sts_i.idx_lt_cnt && sts_i.before_s) begin
          cmd_o.prev_ld = 1'b1;
          cmd_o.idx_sel = ara_pkg::IDX_INC;
        end else begin
          cmd_o.join_ld = 1'b1;
        end
      end
      ara_pkg::S_RJOIN: begin
        if (sts_i.join_prev && sts_i.join_next) begin
          cmd_o.hole_wr  = ara_pkg::HW_BOTH;
          cmd_o.held_clr = 1'b1;
          cmd_o.idx_sel  = ara_pkg::IDX_INC;
        end else if (sts_i.join_prev) begin
          cmd_o.hole_wr  = ara_pkg::HW_PREV;
          cmd_o.held_clr = 1'b1;
        end else if (sts_i.join_next) begin
          cmd_o.hole_wr  = ara_pkg::HW_NEXT;
          cmd_o.held_clr = 1'b1;
        end else if (sts_i.cnt_full) begin
          cmd_o.res_op = ara_pkg::RES_ZERO;
          cmd_o.res_st = ara_pkg::ST_FULL;
        end else begin
          cmd_o.held_clr = 1'b1;
          if (!sts_i.cnt_eq_pos) cmd_o.idx_sel = ara_pkg::IDX_LAST;
        end
      end
      ara_pkg::S_UP: begin
        cmd_o.hole_wr = ara_pkg::HW_UP;
        if (!sts_i.idx_eq_pos) cmd_o.idx_sel = ara_pkg::IDX_DEC;
      end
      ara_pkg::S_INS: begin
        cmd_o.hole_wr = ara_pkg::HW_INSERT;
        cmd_o.cnt_op  = ara_pkg::CNT_INC;
      end
      ara_pkg::S_DONE: cmd_o.out_ld = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* src/address_range_allocator.sv */
// First-fit address range allocator with free-list coalescing.
// Input channel s_axis: tuser = opcode (allocate, release, clear),
//   tdata = client id and request size. Output channel m_axis: one item per
//   input item, tuser = status, tdata = range start and range size.
// An item is taken only while the block is idle; it then runs a controller
//   sequence over the client table memory and the sorted free-list memory.
// Per item: zero size, unused opcode, clear or an unheld release end after
//   the lookup; a held allocate after the client table read; an allocate
//   walks the free list one hole a cycle (up to HOLES) and, on an exact fit,
//   shifts the list one entry a cycle; a release walks to its place and may
//   shift the list the other way. The longest case is an allocate that walks
//   a full list without a fit and falls back to the bump pointer.
// The result sits in an output register; the next item is taken while it
//   waits. When m_axis stalls, a finished second result holds the block
//   until the register frees up.
// Reset empties the client table, the free list and the bump pointer; the
//   clear opcode does the same.
`default_nettype none

module address_range_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // [5:0] client_id, [37:6] request_size, pad
  input  wire logic [1:0]  s_axis_tuser_i,  // [1:0] opcode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o,  // [31:0] range_start, [63:32] range_size
  output logic [2:0]       m_axis_tuser_o   // [2:0] status
);

  ara_pkg::cmd_t cmd;
  ara_pkg::sts_t sts;
  logic [ara_pkg::ADDR_W-1:0] range_start, range_size;

  ara_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ara_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (s_axis_tuser_i),
    .client_id_i    (s_axis_tdata_i[5:0]),
    .request_size_i (s_axis_tdata_i[37:6]),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .status_o       (m_axis_tuser_o),
    .range_start_o  (range_start),
    .range_size_o   (range_size)
  );

  assign m_axis_tdata_o = {range_size, range_start};

endmodule

`default_nettype wire

/* src/ara_checker.sv */
`default_nettype none

module ara_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [63:0] m_axis_tdata_o,
  input wire logic [2:0]  m_axis_tuser_o
);

  // One item at a time: busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while previous item in progress");

  // Status codes stay in range
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o <= ara_pkg::ST_ZERO))
    else $error("status code out of range");

  // Failure results carry no range
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ara_pkg::ST_NOT_HELD ||
      m_axis_tuser_o == ara_pkg::ST_FULL || m_axis_tuser_o == ara_pkg::ST_OVERFLOW ||
      m_axis_tuser_o == ara_pkg::ST_ZERO) |-> (m_axis_tdata_o == 64'd0))
    else $error("failure result with nonzero range");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled output item changed");

endmodule

bind address_range_allocator ara_checker u_ara_checker (.*);

`default_nettype wire
